[hw/rtl/ws2812_frame_buffer_serializer_top_macros.svh]
// Assertion macros for the WS2812 frame buffer serializer.
// Included by the top level; needs no other file.
`ifndef WS2812_FRAME_BUFFER_SERIALIZER_TOP_MACROS_SVH
`define WS2812_FRAME_BUFFER_SERIALIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under reset.
`define WFBS_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication under reset.
`define WFBS_ASSERT_NXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define WFBS_ASSERT_IMP(label, clock, reset, ante, cons)
`define WFBS_ASSERT_NXT(label, clock, reset, ante, cons)
`endif

`endif

[hw/rtl/wfbs_pkg.sv]
// Shared constants, op codes and helper functions for the WS2812 serializer.
// Used by the top level and by the shared divider; depends on nothing.
package wfbs_pkg;

  // Strip geometry.
  localparam int LED_COUNT        = 16;
  localparam int LEAD_RESET_SLOTS = 40;
  localparam int TAIL_RESET_SLOTS = 40;
  localparam int BITS_PER_LED     = 24;
  localparam int DATA_SLOTS       = LED_COUNT * BITS_PER_LED;
  localparam int TOTAL_SLOTS      = LEAD_RESET_SLOTS + DATA_SLOTS + 1 + TAIL_RESET_SLOTS;

  // Derived widths.
  localparam int POS_W   = $clog2(TOTAL_SLOTS + 1);
  localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BIT_W   = 5;
  localparam int COLOR_W = 8;
  localparam int PIXEL_W = 3 * COLOR_W;

  // Shared divider geometry: 16-bit dividend, 9-bit divisor, 8 quotient bits.
  localparam int DIVIDEND_W = 2 * COLOR_W;
  localparam int DIVISOR_W  = COLOR_W + 1;
  localparam int QUOT_W     = COLOR_W;
  localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_SET_PIXEL    = 3'd0,
    OP_UPDATE_PIXEL = 3'd1,
    OP_SET_ALL      = 3'd2,
    OP_CLEAR        = 3'd3,
    OP_TICK         = 3'd4,
    OP_START        = 3'd5,
    OP_STOP         = 3'd6
  } op_t;

  // Slot codes on the output.
  localparam logic [1:0] CODE_RESET = 2'd0;
  localparam logic [1:0] CODE_ZERO  = 2'd1;
  localparam logic [1:0] CODE_ONE   = 2'd2;

  // floor(x / 7) for x below 1536, by reciprocal multiply (2341 / 2^14).
  function automatic logic [COLOR_W-1:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(2341);
    return p[21:14];
  endfunction

  // White blend: floor(c * 6 / 7) + floor(w / 7), at most 254.
  function automatic logic [COLOR_W-1:0] mix_channel(input logic [COLOR_W-1:0] c,
                                                     input logic [COLOR_W-1:0] w);
    logic [10:0] c6;
    c6 = (11'(c) << 2) + (11'(c) << 1);
    return div7(c6) + div7(11'(w));
  endfunction

endpackage

[hw/rtl/wfbs_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on wfbs_pkg for its widths; the quotient must fit in QUOT_W bits.
module wfbs_div import wfbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  logic                 active;
  logic [DIV_CNT_W-1:0] count;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] remainder;
  logic [QUOT_W-1:0]    low;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and compare.
  always_comb begin
    trial = {remainder, low[QUOT_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // Iteration: the upper dividend half seeds the remainder, then one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active    <= 1'b1;
        count     <= DIV_CNT_W'(QUOT_W);
        dvs       <= divisor;
        remainder <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
        low       <= dividend[QUOT_W-1:0];
        quotient  <= '0;
      end else if (active) begin
        if (fits) begin
          remainder <= DIVISOR_W'(trial - {1'b0, dvs});
        end else begin
          remainder <= trial[DIVISOR_W-1:0];
        end
        quotient <= {quotient[QUOT_W-2:0], fits};
        low      <= {low[QUOT_W-2:0], 1'b0};
        count    <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/ws2812_frame_buffer_serializer_top.sv]
// WS2812 frame buffer serializer: 16-entry GRB pixel store and slot sequencer.
// Depends on wfbs_pkg, wfbs_div and the assertion macro header.
// Tick, start, stop: result set in the decode state. Set_all, clear: a sweep that writes
// one pixel per cycle. Set_pixel, update_pixel: three passes through the shared 8-step
// divider, one per channel, then a write state.
// One item at a time; sync reset clears pixels and stops sending, brightness goes to 255.
`include "ws2812_frame_buffer_serializer_top_macros.svh"

module ws2812_frame_buffer_serializer_top import wfbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         op,
  input  logic [7:0]         led_index,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  input  logic [COLOR_W-1:0] white,
  input  logic               mix_white,
  input  logic               brightness_wr,
  input  logic [COLOR_W-1:0] brightness,
  output logic               busy,
  output logic               done,
  output logic               slot_valid,
  output logic [1:0]         slot_code,
  output logic               sending
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MODW,
    S_MUL,
    S_DWAIT,
    S_WRITE,
    S_SWEEP
  } state_t;

  localparam logic [POS_W-1:0]     POS_TOTAL  = POS_W'(TOTAL_SLOTS);
  localparam logic [POS_W-1:0]     POS_LEAD   = POS_W'(LEAD_RESET_SLOTS);
  localparam logic [POS_W-1:0]     POS_DEND   = POS_W'(LEAD_RESET_SLOTS + DATA_SLOTS);
  localparam logic [BIT_W-1:0]     BIT_LAST   = BIT_W'(BITS_PER_LED - 1);
  localparam logic [LED_W-1:0]     LED_LAST   = LED_W'(LED_COUNT - 1);

  state_t               state;
  op_t                  op_q;
  logic [7:0]           idx_raw;
  logic [LED_W-1:0]     idx;
  logic                 mix_q;
  logic [COLOR_W-1:0]   cr, cg, cb, wv;
  logic [COLOR_W-1:0]   peak;
  logic [COLOR_W-1:0]   sr, sg, sb;
  logic [1:0]           ch;
  logic [LED_W-1:0]     sweep;
  logic [COLOR_W-1:0]   bright_level;
  logic [PIXEL_W-1:0]   pixels [LED_COUNT];

  // Slot position and the LED / bit counters that follow it through the data region.
  logic [POS_W-1:0]     pos;
  logic [LED_W-1:0]     led;
  logic [BIT_W-1:0]     bitn;
  logic                 transmitting;

  // Shared divider hookup.
  logic                  div_go;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;

  logic [COLOR_W-1:0]   chan;
  logic [COLOR_W-1:0]   chan_scaled;
  logic [COLOR_W-1:0]   peak_now;
  logic [PIXEL_W-1:0]   pix_word;
  logic                 in_data;
  logic [1:0]           data_code;
  logic [POS_W-1:0]     pos_inc;
  logic [PIXEL_W-1:0]   fill;

  wfbs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot)
  );

  // Channel under scaling, its scaled value, and the brightest channel.
  always_comb begin
    unique case (ch)
      2'd0:    chan = cr;
      2'd1:    chan = cg;
      default: chan = cb;
    endcase
    chan_scaled = (peak == '0) ? '0 : div_quot;
    peak_now = cr;
    if (cg > peak_now) begin
      peak_now = cg;
    end
    if (cb > peak_now) begin
      peak_now = cb;
    end
  end

  // Slot code at the current position; data slots send GRB, MSB first.
  always_comb begin
    pix_word  = pixels[led];
    in_data   = (pos >= POS_LEAD) && (pos < POS_DEND);
    data_code = pix_word[BIT_LAST - bitn] ? CODE_ONE : CODE_ZERO;
    pos_inc   = pos + 1'b1;
    fill      = (op_q == OP_SET_ALL) ? {cg, cr, cb} : '0;
  end

  assign busy    = (state != S_IDLE);
  assign sending = transmitting;

  // Sequencer, pixel store and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      transmitting <= 1'b0;
      pos          <= '0;
      led          <= '0;
      bitn         <= '0;
      done         <= 1'b0;
      slot_valid   <= 1'b0;
      slot_code    <= CODE_RESET;
      div_go       <= 1'b0;
      bright_level <= '1;
      for (int i = 0; i < LED_COUNT; i++) begin
        pixels[i] <= '0;
      end
    end else begin
      done       <= 1'b0;
      slot_valid <= 1'b0;
      slot_code  <= CODE_RESET;
      div_go     <= 1'b0;
      if (brightness_wr) begin
        bright_level <= brightness;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q    <= op_t'(op);
            idx_raw <= led_index;
            cr      <= red;
            cg      <= green;
            cb      <= blue;
            wv      <= white;
            mix_q   <= mix_white;
            state   <= S_DECODE;
          end
        end

        // Blend white if asked, then run the quick ops or dispatch the long ones.
        S_DECODE: begin
          if (mix_q) begin
            cr <= mix_channel(cr, wv);
            cg <= mix_channel(cg, wv);
            cb <= mix_channel(cb, wv);
          end
          state <= S_IDLE;
          unique case (op_q)
            OP_SET_PIXEL, OP_UPDATE_PIXEL: begin
              state <= S_MODW;
            end
            OP_SET_ALL, OP_CLEAR: begin
              sweep <= '0;
              state <= S_SWEEP;
            end
            OP_TICK: begin
              done <= 1'b1;
              if (transmitting) begin
                if (pos < POS_TOTAL) begin
                  slot_valid <= 1'b1;
                  slot_code  <= in_data ? data_code : CODE_RESET;
                  pos        <= pos_inc;
                  if (in_data) begin
                    if (bitn == BIT_LAST) begin
                      bitn <= '0;
                      led  <= led + 1'b1;
                    end else begin
                      bitn <= bitn + 1'b1;
                    end
                  end
                  if (pos_inc >= POS_TOTAL) begin
                    transmitting <= 1'b0;
                  end
                end else begin
                  transmitting <= 1'b0;
                end
              end
            end
            OP_START: begin
              done         <= 1'b1;
              pos          <= '0;
              led          <= '0;
              bitn         <= '0;
              transmitting <= 1'b1;
            end
            OP_STOP: begin
              done         <= 1'b1;
              transmitting <= 1'b0;
            end
            default: begin
              done <= 1'b1;
            end
          endcase
        end

        // Latch the LED index modulo the strip length and the brightest blended channel.
        S_MODW: begin
          peak  <= peak_now;
          idx   <= LED_W'(idx_raw % LED_COUNT);
          ch    <= 2'd0;
          state <= S_MUL;
        end

        // Channel times brightness, registered into the divider.
        S_MUL: begin
          div_dividend <= DIVIDEND_W'(chan) * DIVIDEND_W'(bright_level);
          div_divisor  <= DIVISOR_W'(peak);
          div_go       <= 1'b1;
          state        <= S_DWAIT;
        end

        // Collect one scaled channel; red, green, blue in turn.
        S_DWAIT: begin
          if (div_done) begin
            unique case (ch)
              2'd0:    sr <= chan_scaled;
              2'd1:    sg <= chan_scaled;
              default: sb <= chan_scaled;
            endcase
            if (ch == 2'd2) begin
              state <= S_WRITE;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_MUL;
            end
          end
        end

        // Store the scaled pixel; set_pixel restarts the frame, update_pixel stops it.
        S_WRITE: begin
          pixels[idx] <= {sg, sr, sb};
          if (op_q == OP_SET_PIXEL) begin
            pos          <= '0;
            led          <= '0;
            bitn         <= '0;
            transmitting <= 1'b1;
          end else begin
            transmitting <= 1'b0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        // Write every pixel, one per cycle.
        S_SWEEP: begin
          pixels[sweep] <= fill;
          if (sweep == LED_LAST) begin
            if (op_q == OP_SET_ALL) begin
              pos          <= '0;
              led          <= '0;
              bitn         <= '0;
              transmitting <= 1'b1;
            end else begin
              transmitting <= 1'b0;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is shown only once the block is free again.
  `WFBS_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  // An accepted item holds the block busy in the next cycle.
  `WFBS_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  // A slot flag only comes with a result.
  `WFBS_ASSERT_IMP(a_slot_done, clk, rst, slot_valid, done)
  // A data code is only emitted together with the slot flag.
  `WFBS_ASSERT_IMP(a_code_valid, clk, rst, slot_code != CODE_RESET, slot_valid)

endmodule
